>>> sv/fna_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fna_pkg;

   localparam int NUMBER_W            = 10;
   localparam int COUNT_W             = 11;
   localparam int MAX_NUMBERS_DEFAULT = 1024;
   localparam int REQ_TDATA_W         = 16;
   localparam int REQ_TUSER_W         = 2;
   localparam int RSP_TDATA_W         = 16;
   localparam int RSP_TUSER_W         = 1;

   localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd1024;

   typedef enum logic [1:0] {
      ACT_GET     = 2'd0,
      ACT_CHECK   = 2'd1,
      ACT_RELEASE = 2'd2
   } action_type;

   typedef struct packed {
      logic                valid;
      logic                ok;
      logic [NUMBER_W-1:0] granted;
   } result_type;

endpackage

`default_nettype wire

>>> sv/fna_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module fna_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2,
   localparam int AW = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

>>> sv/fna_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module fna_ctrl
   import fna_pkg::*;
#(
   parameter int MAX_NUMBERS = MAX_NUMBERS_DEFAULT
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_we,
   input  wire logic [COUNT_W-1:0]  csr_wdata,
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   input  wire action_type          req_action,
   input  wire logic [NUMBER_W-1:0] req_number,
   input  wire logic                hold_full,
   output result_type               result
);

   localparam int IDX_W  = $clog2(MAX_NUMBERS);
   localparam int CNT_W  = IDX_W + 1;
   localparam int PW     = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
   localparam int NW     = (NUMBER_W > IDX_W) ? NUMBER_W : IDX_W;
   localparam int CMPW   = (NUMBER_W > CNT_W) ? NUMBER_W : CNT_W;
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_NUMBERS);
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_NUMBERS - 1);

   logic             sweep_ff, sweep_in;
   logic [IDX_W-1:0] sweep_addr_ff, sweep_addr_in;
   logic             busy_ff, busy_in;
   action_type       act_ff, act_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             in_range_ff, in_range_in;
   logic [IDX_W-1:0] head_ff, head_in;
   logic [IDX_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] total_ff, total_in;
   logic [CNT_W-1:0] pool_ff, pool_in;

   logic [COUNT_W-1:0] count_sel;
   logic [PW-1:0]      count_ext;
   logic [CNT_W-1:0]   pool_new;
   logic [IDX_W-1:0]   tail_new;
   logic [NW-1:0]      number_ext;
   logic [NW-1:0]      grant_ext;
   logic               accept;
   logic               get_ok;
   logic               rel_ok;

   logic             ring_wr_en;
   logic [IDX_W-1:0] ring_wr_addr;
   logic [IDX_W-1:0] ring_wr_data;
   logic [IDX_W-1:0] ring_rd_data;
   logic             mark_wr_en;
   logic [IDX_W-1:0] mark_wr_addr;
   logic             mark_wr_data;
   logic             mark_rd_data;

   assign req_tready = !sweep_ff && !busy_ff && !hold_full;
   assign accept     = req_tvalid && req_tready;
   assign number_ext = NW'(req_number);
   assign grant_ext  = NW'(ring_rd_data);
   assign get_ok     = (total_ff != '0);
   assign rel_ok     = in_range_ff && !mark_rd_data && (total_ff != CNT_MAX);

   always_comb begin
      count_sel = csr_we ? csr_wdata : COUNT_RESET;
      count_ext = PW'(count_sel);
      pool_new  = (count_ext > PW'(MAX_NUMBERS)) ? CNT_MAX : CNT_W'(count_ext);
      tail_new  = (pool_new == CNT_MAX) ? '0 : pool_new[IDX_W-1:0];
   end

   always_comb begin
      sweep_in      = sweep_ff;
      sweep_addr_in = sweep_addr_ff;
      busy_in       = accept;
      act_in        = act_ff;
      idx_in        = idx_ff;
      in_range_in   = in_range_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      total_in      = total_ff;
      pool_in       = pool_ff;
      ring_wr_en    = 1'b0;
      ring_wr_addr  = sweep_addr_ff;
      ring_wr_data  = sweep_addr_ff;
      mark_wr_en    = 1'b0;
      mark_wr_addr  = sweep_addr_ff;
      mark_wr_data  = 1'b1;
      result        = '0;

      if (sweep_ff) begin
         ring_wr_en    = 1'b1;
         mark_wr_en    = 1'b1;
         sweep_addr_in = (sweep_addr_ff == IDX_LAST) ? '0 : sweep_addr_ff + 1'b1;
         sweep_in      = (sweep_addr_ff != IDX_LAST);
      end

      if (accept) begin
         act_in      = req_action;
         idx_in      = number_ext[IDX_W-1:0];
         in_range_in = (CMPW'(req_number) < CMPW'(pool_ff));
      end

      if (busy_ff) begin
         result.valid = 1'b1;
         case (act_ff)
            ACT_GET: begin
               result.ok = get_ok;
               if (get_ok) begin
                  result.granted = grant_ext[NUMBER_W-1:0];
                  mark_wr_en     = !sweep_ff;
                  mark_wr_addr   = sweep_ff ? sweep_addr_ff : ring_rd_data;
                  mark_wr_data   = sweep_ff;
                  head_in        = (head_ff == IDX_LAST) ? '0 : head_ff + 1'b1;
                  total_in       = total_ff - 1'b1;
               end
            end
            ACT_CHECK: begin
               result.ok = in_range_ff && mark_rd_data;
            end
            ACT_RELEASE: begin
               result.ok = rel_ok;
               if (rel_ok) begin
                  mark_wr_en   = !sweep_ff;
                  mark_wr_addr = sweep_ff ? sweep_addr_ff : idx_ff;
                  ring_wr_en   = !sweep_ff;
                  ring_wr_addr = sweep_ff ? sweep_addr_ff : tail_ff;
                  ring_wr_data = sweep_ff ? sweep_addr_ff : idx_ff;
                  tail_in      = (tail_ff == IDX_LAST) ? '0 : tail_ff + 1'b1;
                  total_in     = total_ff + 1'b1;
               end
            end
            default: begin
               result.ok = 1'b0;
            end
         endcase
         if (sweep_ff) begin
            mark_wr_en = 1'b1;
            ring_wr_en = 1'b1;
         end
      end

      if (csr_we) begin
         sweep_in      = 1'b1;
         sweep_addr_in = '0;
         busy_in       = 1'b0;
         head_in       = '0;
         tail_in       = tail_new;
         total_in      = pool_new;
         pool_in       = pool_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff      <= 1'b1;
         sweep_addr_ff <= '0;
         busy_ff       <= 1'b0;
         head_ff       <= '0;
         tail_ff       <= tail_new;
         total_ff      <= pool_new;
         pool_ff       <= pool_new;
      end else begin
         sweep_ff      <= sweep_in;
         sweep_addr_ff <= sweep_addr_in;
         busy_ff       <= busy_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         total_ff      <= total_in;
         pool_ff       <= pool_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff      <= act_in;
      idx_ff      <= idx_in;
      in_range_ff <= in_range_in;
   end

   fna_ram #(
      .WIDTH(IDX_W),
      .DEPTH(MAX_NUMBERS)
   ) u_ring (
      .clock  (clock),
      .wr_en  (ring_wr_en),
      .wr_addr(ring_wr_addr),
      .wr_data(ring_wr_data),
      .rd_en  (accept),
      .rd_addr(head_ff),
      .rd_data(ring_rd_data)
   );

   fna_ram #(
      .WIDTH(1),
      .DEPTH(MAX_NUMBERS)
   ) u_mark (
      .clock  (clock),
      .wr_en  (mark_wr_en),
      .wr_addr(mark_wr_addr),
      .wr_data(mark_wr_data),
      .rd_en  (accept),
      .rd_addr(idx_in),
      .rd_data(mark_rd_data)
   );

`ifndef SYNTH
   a_busy_single : assert property (@(posedge clock) disable iff (reset)
      busy_ff |=> !busy_ff)
      else $error("A request stayed in the update cycle twice.");

   a_total_bound : assert property (@(posedge clock) disable iff (reset)
      total_ff <= pool_ff)
      else $error("Free count exceeds the pool size.");

   a_get_count : assert property (@(posedge clock) disable iff (reset)
      busy_ff && (act_ff == ACT_GET) && get_ok && !csr_we
      |=> total_ff == $past(total_ff) - 1'b1)
      else $error("A granted number did not reduce the free count.");
`endif

endmodule

`default_nettype wire

>>> sv/fna_out_q.sv
`timescale 1ns / 1ps
`default_nettype none

module fna_out_q
   import fna_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire result_type             push,
   output logic                        hold_full,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0]      rsp_tdata,
   output logic [RSP_TUSER_W-1:0]      rsp_tuser
);

   result_type out_ff, out_in;
   result_type hold_ff, hold_in;
   logic       out_free;

   assign out_free   = !out_ff.valid || rsp_tready;
   assign hold_full  = hold_ff.valid;
   assign rsp_tvalid = out_ff.valid;
   assign rsp_tdata  = RSP_TDATA_W'(out_ff.granted);
   assign rsp_tuser  = RSP_TUSER_W'(out_ff.ok);

   always_comb begin
      out_in  = out_ff;
      hold_in = hold_ff;
      if (out_free) begin
         if (hold_ff.valid) begin
            out_in        = hold_ff;
            hold_in.valid = 1'b0;
         end else begin
            out_in = push;
         end
      end else if (push.valid) begin
         hold_in = push;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_ff.valid  <= 1'b0;
         hold_ff.valid <= 1'b0;
      end else begin
         out_ff.valid  <= out_in.valid;
         hold_ff.valid <= hold_in.valid;
      end
      out_ff.ok       <= out_in.ok;
      out_ff.granted  <= out_in.granted;
      hold_ff.ok      <= hold_in.ok;
      hold_ff.granted <= hold_in.granted;
   end

`ifndef SYNTH
   a_hold_behind_out : assert property (@(posedge clock) disable iff (reset)
      hold_ff.valid |-> out_ff.valid)
      else $error("Spare entry filled while the output register is empty.");

   a_push_room : assert property (@(posedge clock) disable iff (reset)
      push.valid |-> !hold_ff.valid)
      else $error("Result pushed while the spare entry is in use.");
`endif

endmodule

`default_nettype wire

>>> sv/fifo_number_allocator_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  Ports                      Beat contents
// req      in   req_tvalid/tready/tdata    tdata: number; tuser: action
//                    /tuser
// rsp      out  rsp_tvalid/tready/tdata    tdata: granted_number; tuser: ok
//                    /tuser
// csr      in   csr_we/csr_wdata           number_count, taken when csr_we is high
//
// The free ring and the free marks are read in the accept cycle and updated in the
// next, and no new request beat is taken while that update is in progress.
// After reset and after every csr write a clearing pass over all MAX_NUMBERS entries
// rebuilds both memories; req_tready stays low during it.
// Results pass through a two-entry output queue; while the receiver stalls,
// req_tready also stays low once its second entry is occupied.

module fifo_number_allocator_unit
   import fna_pkg::*;
#(
   parameter int MAX_NUMBERS = MAX_NUMBERS_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_we,
   input  wire logic [COUNT_W-1:0]     csr_wdata,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,  // [9:0] number
   input  wire logic [REQ_TUSER_W-1:0] req_tuser,  // [1:0] action
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0]      rsp_tdata,  // [9:0] granted_number
   output logic [RSP_TUSER_W-1:0]      rsp_tuser   // [0] ok
);

   result_type result;
   logic       hold_full;

   fna_ctrl #(
      .MAX_NUMBERS(MAX_NUMBERS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_action(action_type'(req_tuser)),
      .req_number(req_tdata[NUMBER_W-1:0]),
      .hold_full (hold_full),
      .result    (result)
   );

   fna_out_q u_out_q (
      .clock     (clock),
      .reset     (reset),
      .push      (result),
      .hold_full (hold_full),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

endmodule

`default_nettype wire

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import fna_pkg::*;

   localparam int POOL_MAX = MAX_NUMBERS_DEFAULT;
   localparam int CYCLE_LIMIT = 400000;
   localparam int PRINT_LIMIT = 40;
   localparam logic [1:0] ACT_UNUSED = 2'd3;

   typedef struct packed {
      logic                ok;
      logic [NUMBER_W-1:0] granted;
   } reply_t;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_we = 1'b0;
   logic [COUNT_W-1:0]     csr_wdata = '0;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic [REQ_TUSER_W-1:0] req_tuser = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [RSP_TUSER_W-1:0] rsp_tuser;

   logic                free_mark [POOL_MAX];
   logic [NUMBER_W-1:0] free_ring [POOL_MAX];
   logic [NUMBER_W-1:0] ring_head;
   logic [COUNT_W-1:0]  free_total;
   logic [COUNT_W-1:0]  pool_count = COUNT_RESET;
   logic [NUMBER_W-1:0] taken_numbers [$];
   reply_t              pending_replies [$];

   int  error_count = 0;
   int  cycle_count = 0;
   int  hold_cycles = 0;
   bit  tx_idle_on = 1'b1;
   bit  rx_idle_on = 1'b1;

   fifo_number_allocator_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #6 clock = ~clock;

   function automatic logic [COUNT_W-1:0] pool_limit();
      return (pool_count > COUNT_W'(POOL_MAX)) ? COUNT_W'(POOL_MAX) : pool_count;
   endfunction

   function automatic void clear_pool();
      for (int i = 0; i < POOL_MAX; i++) begin
         free_mark[i] = 1'b1;
         free_ring[i] = NUMBER_W'(i);
      end
      ring_head = '0;
      free_total = pool_limit();
      taken_numbers.delete();
   endfunction

   function automatic reply_t apply_pool_op(input logic [1:0] act,
                                            input logic [NUMBER_W-1:0] num);
      reply_t              r;
      logic                in_range;
      logic [NUMBER_W-1:0] tail;
      int                  hits [$];
      r = '0;
      in_range = {1'b0, num} < pool_limit();
      case (act)
         ACT_GET: begin
            if (free_total != 0) begin
               r.granted = free_ring[ring_head];
               r.ok = 1'b1;
               free_mark[r.granted] = 1'b0;
               ring_head = ring_head + 1'b1;
               free_total = free_total - 1'b1;
               taken_numbers.push_back(r.granted);
            end
         end
         ACT_CHECK: begin
            r.ok = in_range && free_mark[num];
         end
         ACT_RELEASE: begin
            if (in_range && !free_mark[num] && free_total < COUNT_W'(POOL_MAX)) begin
               tail = ring_head + free_total[NUMBER_W-1:0];
               free_ring[tail] = num;
               free_mark[num] = 1'b1;
               free_total = free_total + 1'b1;
               r.ok = 1'b1;
               hits = taken_numbers.find_first_index(x) with (x == num);
               if (hits.size() != 0) begin
                  taken_numbers.delete(hits[0]);
               end
            end
         end
         default: begin
         end
      endcase
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      if (error_count < PRINT_LIMIT) begin
         $display("[%0t] mismatch: %s", $realtime, msg);
      end
      error_count++;
   endtask

   // Called at a falling edge; returns at the falling edge after the beat was taken,
   // with tvalid still high so that back-to-back beats keep it asserted.
   task automatic send_request(input logic [1:0] act, input logic [NUMBER_W-1:0] num);
      while (tx_idle_on && $urandom_range(0, 99) < 32) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= act;
      req_tdata <= {{(REQ_TDATA_W-NUMBER_W){1'b0}}, num};
      do begin
         @(posedge clock);
      end while (req_tready !== 1'b1);
      pending_replies.push_back(apply_pool_op(act, num));
      @(negedge clock);
   endtask

   task automatic drain_replies();
      req_tvalid <= 1'b0;
      while (pending_replies.size() != 0) begin
         @(negedge clock);
      end
      repeat (4) @(negedge clock);
   endtask

   task automatic set_pool_size(input logic [COUNT_W-1:0] count);
      drain_replies();
      csr_we <= 1'b1;
      csr_wdata <= count;
      @(negedge clock);
      csr_we <= 1'b0;
      pool_count = count;
      clear_pool();
   endtask

   task automatic send_random_op();
      int                  pick;
      logic [NUMBER_W-1:0] num;
      pick = $urandom_range(0, 99);
      num = NUMBER_W'($urandom());
      if (pick < 40) begin
         send_request(ACT_GET, num);
      end else if (pick < 70) begin
         if (taken_numbers.size() != 0 && $urandom_range(0, 99) < 85) begin
            num = taken_numbers[$urandom_range(0, taken_numbers.size() - 1)];
         end
         send_request(ACT_RELEASE, num);
      end else if (pick < 96) begin
         if (pool_limit() != 0 && $urandom_range(0, 3) != 0) begin
            num = NUMBER_W'($urandom_range(0, pool_limit() - 1));
         end
         send_request(ACT_CHECK, num);
      end else begin
         send_request(ACT_UNUSED, num);
      end
   endtask

   task automatic test_reset_pool();
      send_request(ACT_CHECK, 10'd0);
      send_request(ACT_CHECK, 10'd1023);
      send_request(ACT_GET, 10'd0);
      send_request(ACT_GET, 10'd1023);
      send_request(ACT_CHECK, 10'd0);
      send_request(ACT_RELEASE, 10'd0);
      send_request(ACT_RELEASE, 10'd0);
      send_request(ACT_CHECK, 10'd0);
      send_request(ACT_RELEASE, 10'd1023);
      send_request(ACT_UNUSED, 10'd1023);
      send_request(ACT_GET, 10'h2AA);
   endtask

   task automatic test_small_pool();
      set_pool_size(11'd3);
      repeat (4) send_request(ACT_GET, 10'd0);
      send_request(ACT_CHECK, 10'd3);
      send_request(ACT_RELEASE, 10'd5);
      send_request(ACT_RELEASE, 10'd1);
      send_request(ACT_RELEASE, 10'd2);
      send_request(ACT_GET, 10'd0);
      send_request(ACT_CHECK, 10'd2);
   endtask

   task automatic test_pool_extremes();
      set_pool_size(11'd0);
      send_request(ACT_GET, 10'd0);
      send_request(ACT_CHECK, 10'd0);
      send_request(ACT_RELEASE, 10'd0);
      set_pool_size(11'h7FF);
      send_request(ACT_CHECK, 10'd1023);
      send_request(ACT_GET, 10'd0);
      set_pool_size(11'd1);
      send_request(ACT_GET, 10'd0);
      send_request(ACT_GET, 10'd0);
      send_request(ACT_RELEASE, 10'd0);
      send_request(ACT_GET, 10'd0);
   endtask

   task automatic test_random_traffic();
      logic [COUNT_W-1:0] sizes [9];
      sizes = '{11'd1, 11'd2, 11'd5, 11'd16, 11'd100, 11'd1024, 11'h7FF, 11'd0,
                COUNT_W'($urandom_range(1, POOL_MAX))};
      foreach (sizes[i]) begin
         set_pool_size(sizes[i]);
         repeat ($urandom_range(20, 30)) send_random_op();
      end
   endtask

   // A pool one short of the ring's depth starts the tail at the last ring entry,
   // so recycled numbers are appended across the ring's wrap point.
   task automatic test_ring_wrap();
      tx_idle_on = 1'b0;
      rx_idle_on = 1'b0;
      set_pool_size(11'd1023);
      repeat (50) begin
         send_request(ACT_GET, NUMBER_W'($urandom()));
         if ($urandom_range(0, 7) == 0) begin
            send_request(ACT_CHECK, NUMBER_W'($urandom()));
         end
         send_request(ACT_RELEASE, taken_numbers[$]);
      end
      tx_idle_on = 1'b1;
      rx_idle_on = 1'b1;
   endtask

   task automatic test_output_stall();
      set_pool_size(11'd16);
      hold_cycles = 300;
      repeat (40) send_random_op();
   endtask

   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !(rx_idle_on && $urandom_range(0, 99) < 32);
      end
   end

   always @(posedge clock) begin
      reply_t want;
      if (rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
         if (pending_replies.size() == 0) begin
            report_mismatch($sformatf("reply with none pending: ok=%b number=%0d",
                                      rsp_tuser[0], rsp_tdata));
         end else begin
            want = pending_replies.pop_front();
            if (rsp_tuser[0] !== want.ok) begin
               report_mismatch($sformatf("ok is %b, predicted %b", rsp_tuser[0], want.ok));
            end
            if (rsp_tdata !== {{(RSP_TDATA_W-NUMBER_W){1'b0}}, want.granted}) begin
               report_mismatch($sformatf("granted number is %0d, predicted %0d",
                                         rsp_tdata, want.granted));
            end
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAIL");
      $finish;
   end

   initial begin
      clear_pool();
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      test_reset_pool();
      test_small_pool();
      test_pool_extremes();
      test_random_traffic();
      test_ring_wrap();
      test_output_stall();
      drain_replies();
      repeat (10) @(posedge clock);
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

>>> fifo_number_allocator_unit.f
sv/fna_pkg.sv
sv/fna_ram.sv
sv/fna_ctrl.sv
sv/fna_out_q.sv
sv/fifo_number_allocator_unit.sv
tb/sv/testbench.sv
